// ===== sv/bounded_deque_engine_macros.svh =====
// assertion macros used by the checker of the deque engine
// depends on nothing; the including module supplies clk and rst_n
`ifndef BOUNDED_DEQUE_ENGINE_MACROS_SVH
`define BOUNDED_DEQUE_ENGINE_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define BDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bde_pkg.sv =====
// shared constants, codes and types of the bounded deque engine
// no dependencies
package bde_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int ITEM_WIDTH_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

  localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STS_ITEM  = 2'd3;

  // broadcast control for the row of storage cells
  typedef struct packed {
    logic shift_l;  // take the right neighbor's data
    logic shift_r;  // take the left neighbor's data
    logic load_en;  // the addressed cell takes the load bus
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

endpackage

// ===== sv/bde_cell.sv =====
// one storage cell of the deque row: holds one item, shifts with its neighbors
// depends on bde_pkg
module bde_cell #(
  parameter int ITEM_WIDTH = bde_pkg::ITEM_WIDTH_DEF,
  parameter int IDX_W      = 6,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  bde_pkg::cell_ctl_t    ctl,
  input  logic [IDX_W-1:0]      load_idx,
  input  logic [ITEM_WIDTH-1:0] load_data,
  input  logic [ITEM_WIDTH-1:0] left_data,
  input  logic [ITEM_WIDTH-1:0] right_data,
  output logic [ITEM_WIDTH-1:0] data
);

  logic [ITEM_WIDTH-1:0] data_r;
  logic [ITEM_WIDTH-1:0] data_nxt;

  always_comb begin
    priority if (ctl.load_en && (load_idx == IDX_W'(INDEX))) begin
      data_nxt = load_data;
    end else if (ctl.shift_r) begin
      data_nxt = left_data;
    end else if (ctl.shift_l) begin
      data_nxt = right_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== sv/bounded_deque_engine.sv =====
// top level of the bounded deque engine: command control, output register
// and a row of bde_cell storage cells; depends on bde_pkg and bde_cell
//
// channel  dir  tdata                          tuser        tlast
// in_      in   [31:0] value                   [2:0] cmd    -
// out_     out  [31:0] item, [38:32] count     [1:0] status last
//
// push, pop, clear and unknown commands: result in the output register the
// cycle after the transaction
// dump of n items: one item per cycle while the output is not stalled, through
// the cell row, which rotates by one cell per item and is back in order at the end
// a stalled output holds the engine; in_tready is low during a dump
// reset clears the item count and control; cell contents are left as they are
module bounded_deque_engine #(
  parameter int CAPACITY   = bde_pkg::CAPACITY_DEF,
  parameter int ITEM_WIDTH = bde_pkg::ITEM_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] item, [38:32] count, [39] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  bde_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [bde_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [bde_pkg::VALUE_W-1:0]   out_item_r, out_item_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [CNT_W-1:0]              out_count_r, out_count_nxt;

  bde_pkg::cell_ctl_t    ctl;
  logic [IDX_W-1:0]      load_idx;
  logic [ITEM_WIDTH-1:0] load_data;
  logic [ITEM_WIDTH-1:0] push_item;
  logic [bde_pkg::VALUE_W-1:0] head_item;
  logic [ITEM_WIDTH-1:0] cell_data [CAPACITY];

  logic out_free;
  logic in_fire;
  logic is_full;
  logic is_empty;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == bde_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign is_empty  = (count_r == '0);

  // width conversion between the 32-bit ports and the stored item width
  generate
    if (ITEM_WIDTH <= 32) begin : g_narrow_in
      assign push_item = in_tdata[ITEM_WIDTH-1:0];
    end else begin : g_wide_in
      assign push_item = {{(ITEM_WIDTH-32){in_tdata[31]}}, in_tdata};
    end
    if (ITEM_WIDTH >= 32) begin : g_wide_out
      assign head_item = cell_data[0][31:0];
    end else begin : g_narrow_out
      assign head_item = {{(32-ITEM_WIDTH){cell_data[0][ITEM_WIDTH-1]}}, cell_data[0]};
    end
  endgenerate

  always_comb begin
    ctl            = '0;
    load_idx       = '0;
    load_data      = push_item;
    state_nxt      = state_r;
    count_nxt      = count_r;
    remain_nxt     = remain_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;

    unique case (state_r)
      bde_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bde_pkg::STS_DONE;
          out_item_nxt   = '0;
          out_last_nxt   = 1'b1;
          unique case (in_tuser)
            bde_pkg::CMD_PUSH_BACK: begin
              if (is_full) begin
                out_status_nxt = bde_pkg::STS_FULL;
              end else begin
                ctl.load_en = 1'b1;
                load_idx    = count_r[IDX_W-1:0];
                count_nxt   = count_r + CNT_W'(1);
              end
            end
            bde_pkg::CMD_PUSH_FRONT: begin
              if (is_full) begin
                out_status_nxt = bde_pkg::STS_FULL;
              end else begin
                ctl.shift_r = 1'b1;
                ctl.load_en = 1'b1;
                count_nxt   = count_r + CNT_W'(1);
              end
            end
            bde_pkg::CMD_POP_FRONT: begin
              if (is_empty) begin
                out_status_nxt = bde_pkg::STS_EMPTY;
              end else begin
                ctl.shift_l = 1'b1;
                count_nxt   = count_r - CNT_W'(1);
              end
            end
            bde_pkg::CMD_DUMP: begin
              if (is_empty) begin
                out_status_nxt = bde_pkg::STS_EMPTY;
              end else begin
                // results come from the dump state
                out_valid_nxt = 1'b0;
                remain_nxt    = count_r;
                state_nxt     = bde_pkg::ST_DUMP;
              end
            end
            bde_pkg::CMD_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
          out_count_nxt = count_nxt;
        end
      end
      bde_pkg::ST_DUMP: begin
        if (out_free) begin
          // head item leaves, row rotates with the head going to the back
          out_valid_nxt  = 1'b1;
          out_status_nxt = bde_pkg::STS_ITEM;
          out_item_nxt   = head_item;
          out_last_nxt   = (remain_r == CNT_W'(1));
          out_count_nxt  = count_r;
          ctl.shift_l    = 1'b1;
          ctl.load_en    = 1'b1;
          load_idx       = IDX_W'(count_r - CNT_W'(1));
          load_data      = cell_data[0];
          remain_nxt     = remain_r - CNT_W'(1);
          if (remain_r == CNT_W'(1)) begin
            state_nxt = bde_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = bde_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bde_pkg::ST_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ITEM_WIDTH-1:0] left_d;
      logic [ITEM_WIDTH-1:0] right_d;
      if (g == 0) begin : g_first
        assign left_d = load_data;
      end else begin : g_mid_l
        assign left_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = cell_data[g+1];
      end
      bde_cell #(
        .ITEM_WIDTH(ITEM_WIDTH),
        .IDX_W     (IDX_W),
        .INDEX     (g)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .load_idx  (load_idx),
        .load_data (load_data),
        .left_data (left_d),
        .right_data(right_d),
        .data      (cell_data[g])
      );
    end
  endgenerate

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, bde_pkg::COUNT_W'(out_count_r), out_item_r};

endmodule

// ===== sv/bde_checker.sv =====
// port-level checker of the bounded deque engine, bound to the top level
// depends on bde_pkg and bounded_deque_engine_macros.svh
`include "bounded_deque_engine_macros.svh"

module bde_checker #(
  parameter int CAPACITY = bde_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result transaction keeps its payload
  `BDE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

  // while a dump still has items to send no new command is taken
  `BDE_ASSERT_NOW(a_dump_busy, out_tvalid && (out_tuser == bde_pkg::STS_ITEM) && !out_tlast, !in_tready, "command taken during dump")

  // status-only results are single and carry a zero item
  `BDE_ASSERT_NOW(a_status_single, out_tvalid && (out_tuser != bde_pkg::STS_ITEM), out_tlast && (out_tdata[31:0] == 32'd0), "status result not single")

  // a dropped push reports a full store, an empty report a zero count
  `BDE_ASSERT_NOW(a_full_count, out_tvalid && (out_tuser == bde_pkg::STS_FULL), out_tdata[38:32] == 7'(CAPACITY), "full status with wrong count")
  `BDE_ASSERT_NOW(a_empty_count, out_tvalid && (out_tuser == bde_pkg::STS_EMPTY), out_tdata[38:32] == 7'd0, "empty status with nonzero count")

endmodule

bind bounded_deque_engine bde_checker #(.CAPACITY(CAPACITY)) u_bde_checker (.*);
